// ===== design/prp_pkg.sv =====
// ----------------------------------------------------------------------------
// prp_pkg: shared types and constants for the packet rate pacer
// Register indexes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package prp_pkg;
    localparam int unsigned RateW   = 31;
    localparam int unsigned WaitW   = 20;
    localparam int unsigned TimeW   = 64;
    localparam int unsigned LenW    = 16;
    localparam int unsigned IntvW   = 39;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] REG_RATE   = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_MAXW   = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_WINDOW = 2'd2;

    localparam logic [WaitW-1:0] MAX_WAIT_RESET = 20'd200000;
    localparam logic [WaitW-1:0] WINDOW_RESET   = 20'd100000;
    localparam logic [23:0]      BITS_PER_US_S  = 24'd8000000;

    localparam logic [1:0] REASON_NONE   = 2'd0;
    localparam logic [1:0] REASON_FIRST  = 2'd1;
    localparam logic [1:0] REASON_BEHIND = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCHED,
        ST_WAIT,
        ST_IDIV,
        ST_WIN,
        ST_LDIV,
        ST_OPEN,
        ST_ODIV,
        ST_DONE
    } state_t;
endpackage
`default_nettype wire

// ===== design/packet_rate_pacer_with_window_stats.sv =====
// ----------------------------------------------------------------------------
// packet_rate_pacer_with_window_stats
// Virtual-clock packet pacer with windowed throughput statistics.
// ----------------------------------------------------------------------------
// Usage: offer one packet (length, arrival time) per item; the block answers
// with the hold time, release time and the window statistics. A bypassed item
// goes from acceptance straight to its result. A paced item passes through the
// schedule, the interval division, the window check, the closing window rate
// division, the loading of the open window rate, that division and the raising
// of the result. A single restoring divider, one quotient bit a cycle, serves
// all three divisions in turn; a division whose quotient saturates or is not
// needed is skipped. The input stalls while an item is in work and while its
// result waits. A finished result waits in the output register until taken.
// Configuration writes are taken only while the block is idle with no result
// waiting; cfg_ready is low otherwise.
`default_nettype none
module packet_rate_pacer_with_window_stats (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [prp_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [31:0]               cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [prp_pkg::LenW-1:0]  packet_length,
    input  wire logic [63:0]               arrival_time_us,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           paced,
    output logic [prp_pkg::WaitW-1:0]      wait_us,
    output logic [63:0]                    send_time_us,
    output logic [prp_pkg::IntvW-1:0]      interval_us,
    output logic [1:0]                     restart_reason,
    output logic                           window_closed,
    output logic [63:0]                    last_window_rate,
    output logic [63:0]                    peak_window_rate,
    output logic [63:0]                    current_window_rate,
    output logic [31:0]                    total_packets,
    output logic [63:0]                    total_bytes,
    output logic [31:0]                    restart_count
);
    prp_pkg::state_t state_reg, state_next;

    // configuration
    logic [30:0] rate_reg;
    logic [19:0] maxw_reg;
    logic [19:0] win_reg;

    // pacing and statistics state
    logic [63:0] nst_reg;
    logic [63:0] wstart_reg;
    logic [47:0] wbytes_reg;
    logic [63:0] last_reg, peak_reg, open_reg;
    logic [31:0] pkts_reg, rst_cnt_reg;
    logic [63:0] bytes_reg;

    // per-item working registers
    logic [15:0] len_reg;
    logic [63:0] now_reg;
    logic [19:0] wait_reg;
    logic [63:0] send_reg;
    logic [38:0] intv_reg;
    logic [1:0]  reason_reg;
    logic        closed_reg;
    logic        paced_reg;
    logic        out_valid_reg;

    // shared divider: {hi, lo} / d, one quotient bit a cycle
    logic [63:0] dhi_reg, dlo_reg, dd_reg;
    logic [6:0]  dcnt_reg;
    logic        dsat_reg;
    logic [64:0] dshift;
    logic        dtake;
    logic [63:0] dhi_step;
    logic [63:0] dlo_step;

    assign dshift   = {dhi_reg, dlo_reg[63]};
    assign dtake    = dshift >= {1'b0, dd_reg};
    assign dhi_step = dtake ? 64'(dshift - {1'b0, dd_reg}) : dshift[63:0];
    assign dlo_step = {dlo_reg[62:0], dtake};
    wire div_done = dcnt_reg == 7'd64;

    // numerator bytes*8e6 as 128 bits (48 x 24 product fits 72 bits)
    function automatic logic [127:0] bits_num(input logic [47:0] b);
        logic [71:0] p;
        begin
            p = b * prp_pkg::BITS_PER_US_S;
            bits_num = {56'd0, p};
        end
    endfunction

    // elapsed window time from the current send time
    wire [63:0] elapsed = (send_reg >= wstart_reg) ? send_reg - wstart_reg : 64'd0;
    wire [47:0] wbytes_add = wbytes_reg + {32'd0, len_reg};

    // window rate numerator; saturate when the quotient cannot fit 64 bits
    wire [127:0] num_full = bits_num(wbytes_reg);
    wire         num_sat  = num_full[127:64] >= elapsed;

    wire accept_in = in_valid && !in_stall;
    wire accept_out = out_valid_reg && !out_stall;
    wire do_pace = (rate_reg != 31'd0) && (packet_length != 16'd0);

    assign cfg_ready = (state_reg == prp_pkg::ST_IDLE) && !out_valid_reg;
    assign in_stall  = (state_reg != prp_pkg::ST_IDLE) || out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prp_pkg::ST_IDLE:  if (accept_in) state_next = do_pace ? prp_pkg::ST_SCHED
                                                                  : prp_pkg::ST_DONE;
            prp_pkg::ST_SCHED: state_next = prp_pkg::ST_WAIT;
            prp_pkg::ST_WAIT:  state_next = prp_pkg::ST_IDIV;
            prp_pkg::ST_IDIV:  if (div_done) state_next = prp_pkg::ST_WIN;
            prp_pkg::ST_WIN:   state_next = prp_pkg::ST_LDIV;
            prp_pkg::ST_LDIV:  if (div_done || dsat_reg) state_next = prp_pkg::ST_OPEN;
            prp_pkg::ST_OPEN:  state_next = prp_pkg::ST_ODIV;
            prp_pkg::ST_ODIV:  if (div_done || dsat_reg) state_next = prp_pkg::ST_DONE;
            prp_pkg::ST_DONE:  if (!out_valid_reg) state_next = prp_pkg::ST_IDLE;
            default:           state_next = prp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prp_pkg::ST_IDLE;
            rate_reg      <= '0;
            maxw_reg      <= prp_pkg::MAX_WAIT_RESET;
            win_reg       <= prp_pkg::WINDOW_RESET;
            nst_reg       <= '0;
            wstart_reg    <= '0;
            wbytes_reg    <= '0;
            last_reg      <= '0;
            peak_reg      <= '0;
            open_reg      <= '0;
            pkts_reg      <= '0;
            rst_cnt_reg   <= '0;
            bytes_reg     <= '0;
            out_valid_reg <= 1'b0;
            dcnt_reg      <= '0;
            dsat_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept_out) out_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    prp_pkg::REG_RATE:
                    begin
                        rate_reg <= cfg_data[30:0];
                        if (cfg_data[30:0] == 31'd0) nst_reg <= '0;
                    end
                    prp_pkg::REG_MAXW:   maxw_reg <= cfg_data[19:0];
                    prp_pkg::REG_WINDOW: win_reg  <= cfg_data[19:0];
                    default: ;
                endcase
            end

            // divider runs in its states until its count ends
            if (state_reg == prp_pkg::ST_IDIV || state_reg == prp_pkg::ST_LDIV
                || state_reg == prp_pkg::ST_ODIV)
            begin
                if (!div_done && !dsat_reg)
                begin
                    dhi_reg  <= dhi_step;
                    dlo_reg  <= dlo_step;
                    dcnt_reg <= dcnt_reg + 7'd1;
                end
            end

            unique case (state_reg)
                prp_pkg::ST_IDLE:
                begin
                    if (accept_in)
                    begin
                        len_reg    <= packet_length;
                        now_reg    <= arrival_time_us;
                        send_reg   <= arrival_time_us;
                        wait_reg   <= '0;
                        intv_reg   <= '0;
                        reason_reg <= prp_pkg::REASON_NONE;
                        closed_reg <= 1'b0;
                        paced_reg  <= do_pace;
                    end
                end
                prp_pkg::ST_SCHED:
                begin
                    if (nst_reg == 64'd0)
                    begin
                        nst_reg     <= now_reg;
                        reason_reg  <= prp_pkg::REASON_FIRST;
                        rst_cnt_reg <= rst_cnt_reg + 32'd1;
                    end
                    else if (now_reg > nst_reg
                             && (now_reg - nst_reg) > {44'd0, maxw_reg})
                    begin
                        nst_reg     <= now_reg;
                        reason_reg  <= prp_pkg::REASON_BEHIND;
                        rst_cnt_reg <= rst_cnt_reg + 32'd1;
                    end
                end
                prp_pkg::ST_WAIT:
                begin
                    // cap the hold, then start the interval division
                    if (nst_reg > now_reg)
                    begin
                        if ((nst_reg - now_reg) > {44'd0, maxw_reg})
                        begin
                            wait_reg <= maxw_reg;
                            send_reg <= now_reg + {44'd0, maxw_reg};
                            if (nst_reg < now_reg + {44'd0, maxw_reg})
                                nst_reg <= now_reg + {44'd0, maxw_reg};
                        end
                        else
                        begin
                            wait_reg <= 20'(nst_reg - now_reg);
                            send_reg <= nst_reg;
                        end
                    end
                    dhi_reg  <= '0;
                    dlo_reg  <= 64'(({8'd0, len_reg} * prp_pkg::BITS_PER_US_S)
                                    + {9'd0, rate_reg} - 40'd1);
                    dd_reg   <= {33'd0, rate_reg};
                    dcnt_reg <= '0;
                    dsat_reg <= 1'b0;
                end
                prp_pkg::ST_IDIV:
                begin
                    if (div_done)
                    begin
                        intv_reg <= (dlo_reg == 64'd0) ? 39'd1 : dlo_reg[38:0];
                        nst_reg  <= nst_reg + ((dlo_reg == 64'd0) ? 64'd1 : dlo_reg);
                        if (wstart_reg == 64'd0) wstart_reg <= send_reg;
                    end
                end
                prp_pkg::ST_WIN:
                begin
                    // close the window if due; load the rate division
                    closed_reg <= elapsed >= {44'd0, win_reg};
                    dhi_reg    <= num_full[127:64];
                    dlo_reg    <= num_sat ? '1 : num_full[63:0];
                    dd_reg     <= elapsed;
                    if (elapsed >= {44'd0, win_reg} && elapsed != 64'd0)
                    begin
                        dcnt_reg <= '0;
                        dsat_reg <= num_sat;
                    end
                    else
                    begin
                        dcnt_reg <= 7'd64;
                        dsat_reg <= 1'b1;
                    end
                end
                prp_pkg::ST_LDIV:
                begin
                    if (div_done || dsat_reg)
                    begin
                        if (closed_reg)
                        begin
                            if (!(dcnt_reg == 7'd64 && dd_reg == 64'd0 && !dsat_reg)
                                && elapsed != 64'd0)
                            begin
                                last_reg <= dlo_reg;
                                if (dlo_reg > peak_reg) peak_reg <= dlo_reg;
                            end
                            wstart_reg <= send_reg;
                            wbytes_reg <= {32'd0, len_reg};
                        end
                        else
                            wbytes_reg <= wbytes_add;
                        pkts_reg  <= pkts_reg + 32'd1;
                        bytes_reg <= bytes_reg + {48'd0, len_reg};
                    end
                end
                prp_pkg::ST_OPEN:
                begin
                    // hold the open rate when no time has passed
                    dd_reg   <= elapsed;
                    dhi_reg  <= num_full[127:64];
                    dlo_reg  <= num_sat ? '1 : num_full[63:0];
                    dcnt_reg <= (elapsed == 64'd0) ? 7'd64 : 7'd0;
                    dsat_reg <= (elapsed != 64'd0) && num_sat;
                end
                prp_pkg::ST_ODIV:
                begin
                    if ((div_done || dsat_reg) && dd_reg != 64'd0)
                        open_reg <= dlo_reg;
                end
                prp_pkg::ST_DONE:
                begin
                    if (!out_valid_reg) out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign out_valid           = out_valid_reg;
    assign paced               = paced_reg;
    assign wait_us             = wait_reg;
    assign send_time_us        = send_reg;
    assign interval_us         = intv_reg;
    assign restart_reason      = reason_reg;
    assign window_closed       = closed_reg;
    assign last_window_rate    = last_reg;
    assign peak_window_rate    = peak_reg;
    assign current_window_rate = open_reg;
    assign total_packets       = pkts_reg;
    assign total_bytes         = bytes_reg;
    assign restart_count       = rst_cnt_reg;
endmodule
`default_nettype wire

// ===== design/prp_checker.sv =====
// ----------------------------------------------------------------------------
// prp_checker: port-level checks for the packet rate pacer
// Watches handshakes and result consistency on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module prp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        paced,
    input wire logic [19:0] wait_us,
    input wire logic [63:0] send_time_us,
    input wire logic [1:0]  restart_reason
);
    // an accepted item blocks the input on the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while busy");
    // a waiting result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(send_time_us)))
        else $error("result changed while stalled");
    // a bypassed item has no wait and no restart
    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !paced)
            |-> (wait_us == 20'd0 && restart_reason == prp_pkg::REASON_NONE))
        else $error("bypass result carries pacing");
    // no input taken while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open with result pending");
endmodule

bind packet_rate_pacer_with_window_stats prp_checker u_prp_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .paced(paced),
    .wait_us(wait_us), .send_time_us(send_time_us),
    .restart_reason(restart_reason)
);
`default_nettype wire
